// ===== hw/rtl/fbad_pkg.sv =====
// ----------------------------------------------------------------------------
// Fractional bin average decimator package
// Shared constants, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package fbad_pkg;

	localparam int SAMPLE_BITS = 32;
	localparam int CNT_BITS    = 10;
	localparam logic [CNT_BITS-1:0] CNT_MAX = 10'd1023;
	localparam logic [15:0] ONE_Q8 = 16'd256;

	localparam logic [1:0] REG_BIN_WIDTH    = 2'd0;
	localparam logic [1:0] REG_ZERO_INDEX   = 2'd1;
	localparam logic [1:0] REG_SAMPLE_COUNT = 2'd2;

	localparam logic [1:0] ST_BINNED = 2'd0;
	localparam logic [1:0] ST_PASS   = 2'd1;
	localparam logic [1:0] ST_ERROR  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_QDIV,
		S_ACCUM,
		S_CMP,
		S_MDIV,
		S_EMIT,
		S_LCHK,
		S_LRD,
		S_LACC,
		S_END
	} state_t;

endpackage

// ===== hw/rtl/fbad_if.sv =====
// ----------------------------------------------------------------------------
// Fractional bin average decimator channels
// Valid/ready channels for input samples and for results.
// ----------------------------------------------------------------------------
interface fbad_sample_if;
	logic                              valid;
	logic                              ready;
	logic signed [fbad_pkg::SAMPLE_BITS-1:0] sample;
	logic                              sample_ok;

	modport source (output valid, output sample, output sample_ok, input ready);
	modport sink (input valid, input sample, input sample_ok, output ready);
endinterface

interface fbad_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [fbad_pkg::SAMPLE_BITS-1:0] average;
	logic                              empty_res;
	logic [1:0]                        status;
	logic [16:0]                       bin_count;
	logic [15:0]                       new_zero;
	logic                              final_res;

	modport source (output valid, output average, output empty_res, output status,
		output bin_count, output new_zero, output final_res, input ready);
	modport sink (input valid, input average, input empty_res, input status,
		input bin_count, input new_zero, input final_res, output ready);
endinterface

// ===== hw/rtl/fbad_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fbad_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/fbad_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Unsigned restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbad_div #(
	parameter int DW = 45,
	parameter int VW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder
);

	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
				quo_q <= {quo_q[DW-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/fractional_bin_average_decimator.sv =====
// ----------------------------------------------------------------------------
// Fractional bin average decimator
// Averages valid samples into bins of Q8.8 width, one serial divider shared.
// ----------------------------------------------------------------------------
// Samples enter on the samples channel and averaged bins leave on the results
// channel; both are valid/ready and a transaction happens when both are high.
// Registers are written through wr_en, wr_index and wr_data; the user must
// write them only while idle, the block itself does not enforce this.
// One sample is taken at a time: samples.ready is high only when the
// sequencer is idle. Each binned sample takes one pass of the 42-step serial
// divider that derives the first edge; a pass-through sample skips it.
// A closing bin with valid samples takes a second divider pass, and a leftover
// bin at the end of a run reads each history entry in turn, in S_LRD and
// S_LACC, then takes a divider pass if it holds valid samples; at most 255
// entries are read for one leftover bin.
// Results are held in an output register; when the receiver stalls, the
// sequencer waits on that register and takes no new sample meanwhile.
// Reset restores unit width, zero index 0 and a run length of one sample,
// and clears the run state; the history memory needs no clearing.
// ----------------------------------------------------------------------------
module fractional_bin_average_decimator #(
	parameter int MAX_BIN_WIDTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	fbad_sample_if.sink samples,
	fbad_result_if.source results,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [16:0] wr_data
);

	localparam int SB    = fbad_pkg::SAMPLE_BITS;
	localparam int AW    = $clog2(MAX_BIN_WIDTH);
	localparam int LC_W  = $clog2(MAX_BIN_WIDTH + 1);
	localparam int CW    = (LC_W > fbad_pkg::CNT_BITS) ? LC_W : fbad_pkg::CNT_BITS;
	localparam int ACC_W = SB + CW;
	localparam int DIV_W = (ACC_W > 24) ? ACC_W : 24;

	fbad_pkg::state_t state_q, state_d;

	logic [15:0] w_q;
	logic [15:0] z_q;
	logic [16:0] n_q;

	logic signed [SB-1:0]    s_q;
	logic                    ok_q;
	logic                    last_q;
	logic [16:0]             pos_q;
	logic signed [25:0]      edge_q;
	logic signed [ACC_W-1:0] sum_q;
	logic [fbad_pkg::CNT_BITS-1:0] cnt_q;
	logic [16:0]             bins_q;
	logic [23:0]             q_q;
	logic [AW-1:0]           ptr_q;
	logic [AW-1:0]           rd_q;
	logic [LC_W-1:0]         m_q;
	logic [LC_W-1:0]         idx_q;
	logic [LC_W-1:0]         lcnt_q;
	logic                    lft_q;
	logic                    after_q;

	logic signed [SB-1:0] p_avg_q;
	logic                 p_empty_q;
	logic [1:0]           p_status_q;
	logic [16:0]          p_bins_q;
	logic [15:0]          p_nz_q;
	logic                 p_final_q;

	logic signed [SB-1:0] o_avg_q;
	logic                 o_empty_q;
	logic [1:0]           o_status_q;
	logic [16:0]          o_bins_q;
	logic [15:0]          o_nz_q;
	logic                 o_final_q;
	logic                 o_valid_q;

	logic              accept;
	logic              out_free;
	logic              pass_mode;
	logic              err_mode;
	logic              last_now;
	logic signed [25:0] pos_s;
	logic              in_bin;
	logic              close;
	logic              leftover;
	logic              fin_close;
	logic [15:0]       nz_sat;
	logic [ACC_W-1:0]  mag;
	logic [SB-1:0]     mean;
	logic [17:0]       m_span;
	logic [17:0]       pos_inc;
	logic [AW-1:0]     ptr_prev;

	logic              div_start;
	logic [DIV_W-1:0]  div_dvd;
	logic [15:0]       div_dvs;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;
	logic [15:0]       div_rem;

	logic [SB:0]       ram_rdata;
	logic signed [ACC_W-1:0] hist_ext;

	assign accept   = samples.valid && samples.ready;
	assign out_free = !o_valid_q || results.ready;

	assign pass_mode = (n_q != 17'd0) && (w_q == fbad_pkg::ONE_Q8);
	assign err_mode  = (n_q == 17'd0) || (w_q == 16'd0) || ({1'b0, z_q} >= n_q);
	assign last_now  = ({1'b0, pos_q} + 18'd1) >= {1'b0, n_q};

	assign pos_s    = $signed({1'b0, pos_q, 8'h00});
	assign in_bin   = (q_q != 24'd0) || (pos_q >= {1'b0, z_q});
	assign close    = in_bin && (pos_s >= edge_q);
	assign leftover = last_q && ((pos_s + $signed({10'b0, w_q})) != edge_q);
	assign fin_close = last_q && (pos_s == edge_q);
	assign nz_sat   = (q_q[23:16] != 8'd0) ? 16'hFFFF : q_q[15:0];

	assign mag  = sum_q[ACC_W-1] ? ACC_W'(-sum_q) : ACC_W'(sum_q);
	assign mean = sum_q[ACC_W-1] ? SB'(-div_quo[SB-1:0]) : div_quo[SB-1:0];

	assign pos_inc = {1'b0, pos_q} + 18'd1;
	always_comb begin
		m_span = {10'b0, w_q[15:8]};
		if (pos_inc < m_span) begin
			m_span = pos_inc;
		end
		if (18'(MAX_BIN_WIDTH) < m_span) begin
			m_span = 18'(MAX_BIN_WIDTH);
		end
	end

	assign ptr_prev = (ptr_q == '0) ? AW'(MAX_BIN_WIDTH - 1) : ptr_q - 1'b1;
	assign hist_ext = $signed({{(ACC_W-SB){ram_rdata[SB-1]}}, ram_rdata[SB-1:0]});

	fbad_ram #(
		.WIDTH(SB + 1),
		.DEPTH(MAX_BIN_WIDTH)
	) u_hist (
		.clk  (clk),
		.we   (accept),
		.waddr(ptr_q),
		.wdata({samples.sample_ok, samples.sample}),
		.raddr(rd_q),
		.rdata(ram_rdata)
	);

	fbad_div #(
		.DW(DIV_W),
		.VW(16)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbad_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		unique case (state_q)
			fbad_pkg::S_IDLE: begin
				if (accept) begin
					state_d = fbad_pkg::S_DECIDE;
				end
			end
			fbad_pkg::S_DECIDE: begin
				if (pass_mode) begin
					state_d = fbad_pkg::S_EMIT;
				end else if (err_mode) begin
					state_d = last_q ? fbad_pkg::S_EMIT : fbad_pkg::S_END;
				end else begin
					div_start = 1'b1;
					div_dvd   = DIV_W'({z_q, 8'h00});
					div_dvs   = w_q;
					state_d   = fbad_pkg::S_QDIV;
				end
			end
			fbad_pkg::S_QDIV: begin
				if (div_done) begin
					state_d = fbad_pkg::S_ACCUM;
				end
			end
			fbad_pkg::S_ACCUM: begin
				state_d = fbad_pkg::S_CMP;
			end
			fbad_pkg::S_CMP: begin
				if (!close) begin
					state_d = fbad_pkg::S_LCHK;
				end else if (cnt_q == '0) begin
					state_d = fbad_pkg::S_EMIT;
				end else begin
					div_start = 1'b1;
					div_dvd   = DIV_W'(mag);
					div_dvs   = 16'(cnt_q);
					state_d   = fbad_pkg::S_MDIV;
				end
			end
			fbad_pkg::S_MDIV: begin
				if (div_done) begin
					state_d = fbad_pkg::S_EMIT;
				end
			end
			fbad_pkg::S_EMIT: begin
				if (out_free) begin
					state_d = after_q ? fbad_pkg::S_LCHK : fbad_pkg::S_END;
				end
			end
			fbad_pkg::S_LCHK: begin
				state_d = leftover ? fbad_pkg::S_LRD : fbad_pkg::S_END;
			end
			fbad_pkg::S_LRD: begin
				if (idx_q != m_q) begin
					state_d = fbad_pkg::S_LACC;
				end else if (lcnt_q == '0) begin
					state_d = fbad_pkg::S_EMIT;
				end else begin
					div_start = 1'b1;
					div_dvd   = DIV_W'(mag);
					div_dvs   = 16'(lcnt_q);
					state_d   = fbad_pkg::S_MDIV;
				end
			end
			fbad_pkg::S_LACC: begin
				state_d = fbad_pkg::S_LRD;
			end
			fbad_pkg::S_END: begin
				state_d = fbad_pkg::S_IDLE;
			end
			default: begin
				state_d = fbad_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= fbad_pkg::ONE_Q8;
			z_q <= '0;
			n_q <= 17'd1;
		end else if (wr_en) begin
			unique case (wr_index)
				fbad_pkg::REG_BIN_WIDTH:    w_q <= wr_data[15:0];
				fbad_pkg::REG_ZERO_INDEX:   z_q <= wr_data[15:0];
				fbad_pkg::REG_SAMPLE_COUNT: n_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q        <= '0;
			ok_q       <= 1'b0;
			last_q     <= 1'b0;
			pos_q      <= '0;
			edge_q     <= '0;
			sum_q      <= '0;
			cnt_q      <= '0;
			bins_q     <= '0;
			q_q        <= '0;
			ptr_q      <= '0;
			rd_q       <= '0;
			m_q        <= '0;
			idx_q      <= '0;
			lcnt_q     <= '0;
			lft_q      <= 1'b0;
			after_q    <= 1'b0;
			p_avg_q    <= '0;
			p_empty_q  <= 1'b0;
			p_status_q <= fbad_pkg::ST_BINNED;
			p_bins_q   <= '0;
			p_nz_q     <= '0;
			p_final_q  <= 1'b0;
		end else begin
			unique case (state_q)
				fbad_pkg::S_IDLE: begin
					if (accept) begin
						s_q    <= samples.sample;
						ok_q   <= samples.sample_ok;
						last_q <= last_now;
						lft_q  <= 1'b0;
						ptr_q  <= (ptr_q == AW'(MAX_BIN_WIDTH - 1)) ? '0 : ptr_q + 1'b1;
					end
				end
				fbad_pkg::S_DECIDE: begin
					after_q <= 1'b0;
					if (pass_mode) begin
						p_avg_q    <= s_q;
						p_empty_q  <= !ok_q;
						p_status_q <= fbad_pkg::ST_PASS;
						p_final_q  <= last_q;
						p_bins_q   <= last_q ? n_q : 17'd0;
						p_nz_q     <= last_q ? z_q : 16'd0;
					end else begin
						p_avg_q    <= '0;
						p_empty_q  <= 1'b0;
						p_status_q <= fbad_pkg::ST_ERROR;
						p_final_q  <= 1'b1;
						p_bins_q   <= '0;
						p_nz_q     <= '0;
					end
				end
				fbad_pkg::S_QDIV: begin
					if (div_done) begin
						q_q <= div_quo[23:0];
						if (pos_q == '0) begin
							if (div_quo[23:0] != 24'd0) begin
								edge_q <= $signed({9'b0, {1'b0, div_rem} + {1'b0, w_q}});
							end else begin
								edge_q <= $signed({2'b0, z_q, 8'h00}) +
									$signed({10'b0, w_q}) - 26'sd256;
							end
						end
					end
				end
				fbad_pkg::S_ACCUM: begin
					if (in_bin && ok_q) begin
						sum_q <= sum_q + $signed({{(ACC_W-SB){s_q[SB-1]}}, s_q});
						if (cnt_q != fbad_pkg::CNT_MAX) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				fbad_pkg::S_CMP: begin
					if (close && cnt_q == '0) begin
						p_avg_q    <= '0;
						p_empty_q  <= 1'b1;
						p_status_q <= fbad_pkg::ST_BINNED;
						p_final_q  <= fin_close;
						p_bins_q   <= fin_close ? bins_q + 1'b1 : 17'd0;
						p_nz_q     <= fin_close ? nz_sat : 16'd0;
						after_q    <= 1'b1;
						bins_q     <= bins_q + 1'b1;
						sum_q      <= '0;
						edge_q     <= edge_q + $signed({10'b0, w_q});
					end
				end
				fbad_pkg::S_MDIV: begin
					if (div_done) begin
						p_avg_q    <= mean;
						p_empty_q  <= 1'b0;
						p_status_q <= fbad_pkg::ST_BINNED;
						bins_q     <= bins_q + 1'b1;
						if (lft_q) begin
							p_final_q <= 1'b1;
							p_bins_q  <= bins_q + 1'b1;
							p_nz_q    <= nz_sat;
							after_q   <= 1'b0;
						end else begin
							p_final_q <= fin_close;
							p_bins_q  <= fin_close ? bins_q + 1'b1 : 17'd0;
							p_nz_q    <= fin_close ? nz_sat : 16'd0;
							after_q   <= 1'b1;
							sum_q     <= '0;
							cnt_q     <= '0;
							edge_q    <= edge_q + $signed({10'b0, w_q});
						end
					end
				end
				fbad_pkg::S_EMIT: begin
				end
				fbad_pkg::S_LCHK: begin
					if (leftover) begin
						m_q    <= LC_W'(m_span);
						idx_q  <= '0;
						lcnt_q <= '0;
						sum_q  <= '0;
						rd_q   <= ptr_prev;
						lft_q  <= 1'b1;
					end
				end
				fbad_pkg::S_LRD: begin
					if (idx_q == m_q && lcnt_q == '0) begin
						p_avg_q    <= '0;
						p_empty_q  <= 1'b1;
						p_status_q <= fbad_pkg::ST_BINNED;
						p_final_q  <= 1'b1;
						p_bins_q   <= bins_q + 1'b1;
						p_nz_q     <= nz_sat;
						after_q    <= 1'b0;
						bins_q     <= bins_q + 1'b1;
					end
				end
				fbad_pkg::S_LACC: begin
					if (ram_rdata[SB]) begin
						sum_q  <= sum_q + hist_ext;
						lcnt_q <= lcnt_q + 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					rd_q  <= (rd_q == '0) ? AW'(MAX_BIN_WIDTH - 1) : rd_q - 1'b1;
				end
				fbad_pkg::S_END: begin
					if (last_q) begin
						pos_q  <= '0;
						sum_q  <= '0;
						cnt_q  <= '0;
						bins_q <= '0;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q  <= 1'b0;
			o_avg_q    <= '0;
			o_empty_q  <= 1'b0;
			o_status_q <= fbad_pkg::ST_BINNED;
			o_bins_q   <= '0;
			o_nz_q     <= '0;
			o_final_q  <= 1'b0;
		end else begin
			if (state_q == fbad_pkg::S_EMIT && out_free) begin
				o_valid_q  <= 1'b1;
				o_avg_q    <= p_avg_q;
				o_empty_q  <= p_empty_q;
				o_status_q <= p_status_q;
				o_bins_q   <= p_bins_q;
				o_nz_q     <= p_nz_q;
				o_final_q  <= p_final_q;
			end else if (results.ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	assign samples.ready     = (state_q == fbad_pkg::S_IDLE);
	assign results.valid     = o_valid_q;
	assign results.average   = o_avg_q;
	assign results.empty_res = o_empty_q;
	assign results.status    = o_status_q;
	assign results.bin_count = o_bins_q;
	assign results.new_zero  = o_nz_q;
	assign results.final_res = o_final_q;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Fractional bin average decimator testbench
// Drives runs of samples under many width, zero index and run length settings,
// predicts every averaged bin, pass-through sample and error result, and
// compares each result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int  HIST_DEPTH  = 256;
	localparam longint CYCLE_LIMIT = 10000000;
	localparam int  DRAIN_CYCLES = 1000;

	typedef struct packed {
		logic signed [31:0] average;
		logic               empty_res;
		logic [1:0]         status;
		logic [16:0]        bin_count;
		logic [15:0]        new_zero;
		logic               final_res;
	} bin_result_t;

	typedef struct packed {
		logic signed [31:0] sample;
		logic               sample_ok;
	} sample_item_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [16:0] wr_data;

	fbad_sample_if samples ();
	fbad_result_if results ();

	fractional_bin_average_decimator dut (
		.clk(clk), .arst_n(arst_n), .samples(samples), .results(results),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	sample_item_t pending_samples[$];
	bin_result_t  expected_bins[$];

	logic [15:0] cur_width;
	logic [15:0] cur_zero;
	logic [16:0] cur_count;
	longint      run_pos;
	longint      edge_q8;
	logic [63:0] acc_sum;
	int          acc_cnt;
	longint      bins_done;
	logic [32:0] history[HIST_DEPTH];
	int          hist_ptr;

	int     errors;
	longint cycles;
	bit     sample_taken;
	bit     quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] bin_mean(logic [63:0] sum, int cnt);
		longint s;
		s = sum;
		if (cnt == 0)
			return 32'd0;
		return 32'(s / longint'(cnt));
	endfunction

	task automatic predict_sample(sample_item_t it);
		bin_result_t r[2];
		int          k;
		longint      w, z, n, q, start, s, m;
		logic [63:0] lsum;
		int          lcnt;
		logic [32:0] e;
		bit          last;
		w = cur_width;
		z = cur_zero;
		n = cur_count;
		s = it.sample;
		k = 0;
		last = (run_pos + 1 >= n);
		history[hist_ptr] = {it.sample_ok, it.sample};
		hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
		r[0] = '0;
		r[1] = '0;
		q = 0;
		if (n != 0 && w == 256) begin
			r[0].average = it.sample;
			r[0].empty_res = ~it.sample_ok;
			r[0].status = fbad_pkg::ST_PASS;
			if (last) begin
				r[0].bin_count = n[16:0];
				r[0].new_zero = z[15:0];
				r[0].final_res = 1'b1;
			end
			k = 1;
		end else if (n == 0 || w == 0 || z >= n) begin
			if (last) begin
				r[0].status = fbad_pkg::ST_ERROR;
				r[0].final_res = 1'b1;
				k = 1;
			end
		end else begin
			q = (z * 256) / w;
			start = (q >= 1) ? 0 : z;
			if (run_pos == 0)
				edge_q8 = (q >= 1) ? ((z * 256) % w + w) : (z * 256 + w - 256);
			if (run_pos >= start) begin
				if (it.sample_ok) begin
					acc_sum = acc_sum + 64'(s);
					if (acc_cnt < 1023)
						acc_cnt++;
				end
				if (run_pos * 256 >= edge_q8) begin
					r[k].average = bin_mean(acc_sum, acc_cnt);
					r[k].empty_res = (acc_cnt == 0);
					r[k].status = fbad_pkg::ST_BINNED;
					k++;
					bins_done++;
					acc_sum = '0;
					acc_cnt = 0;
					edge_q8 += w;
				end
			end
			if (last && run_pos * 256 + w != edge_q8) begin
				m = w >> 8;
				if (m > run_pos + 1)
					m = run_pos + 1;
				if (m > HIST_DEPTH)
					m = HIST_DEPTH;
				lsum = '0;
				lcnt = 0;
				for (int i = 0; i < m; i++) begin
					e = history[(hist_ptr + 2 * HIST_DEPTH - 1 - i) % HIST_DEPTH];
					if (e[32]) begin
						lsum = lsum + 64'(longint'($signed(e[31:0])));
						lcnt++;
					end
				end
				r[k].average = bin_mean(lsum, lcnt);
				r[k].empty_res = (lcnt == 0);
				r[k].status = fbad_pkg::ST_BINNED;
				k++;
				bins_done++;
			end
			if (last && k > 0) begin
				r[k-1].bin_count = bins_done[16:0];
				r[k-1].new_zero = (q > 65535) ? 16'hFFFF : q[15:0];
				r[k-1].final_res = 1'b1;
			end
		end
		for (int i = 0; i < k; i++)
			expected_bins.push_back(r[i]);
		if (last) begin
			run_pos = 0;
			acc_sum = '0;
			acc_cnt = 0;
			bins_done = 0;
		end else begin
			run_pos++;
		end
	endtask

	always @(posedge clk) begin
		bin_result_t got, want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
		sample_taken = 1'b0;
		if (arst_n && samples.valid && samples.ready) begin
			predict_sample({samples.sample, samples.sample_ok});
			sample_taken = 1'b1;
		end
		if (arst_n && results.valid && results.ready) begin
			got = {results.average, results.empty_res, results.status,
				results.bin_count, results.new_zero, results.final_res};
			if (expected_bins.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected result transaction: %p", got);
			end else begin
				want = expected_bins.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("Mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			samples.valid <= 1'b0;
			results.ready <= 1'b0;
		end else begin
			results.ready <= quiet || ($urandom_range(99) >= 14);
			if (!samples.valid || sample_taken) begin
				if (pending_samples.size() > 0 && (quiet || $urandom_range(99) >= 14)) begin
					samples.sample <= pending_samples[0].sample;
					samples.sample_ok <= pending_samples[0].sample_ok;
					samples.valid <= 1'b1;
					void'(pending_samples.pop_front());
				end else begin
					samples.valid <= 1'b0;
				end
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [16:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			fbad_pkg::REG_BIN_WIDTH:    cur_width = value[15:0];
			fbad_pkg::REG_ZERO_INDEX:   cur_zero = value[15:0];
			fbad_pkg::REG_SAMPLE_COUNT: cur_count = value;
			default: ;
		endcase
	endtask

	function automatic sample_item_t rand_sample();
		sample_item_t it;
		case ($urandom_range(9))
			0: it.sample = 32'h7FFFFFFF;
			1: it.sample = 32'h80000000;
			2: it.sample = $signed(32'($urandom_range(200))) - 100;
			default: it.sample = $urandom;
		endcase
		it.sample_ok = ($urandom_range(9) != 0);
		return it;
	endfunction

	task automatic run_phase(logic [15:0] w, logic [15:0] z, logic [16:0] n, int items);
		write_reg(fbad_pkg::REG_BIN_WIDTH, {1'b0, w});
		write_reg(fbad_pkg::REG_ZERO_INDEX, {1'b0, z});
		write_reg(fbad_pkg::REG_SAMPLE_COUNT, n);
		for (int i = 0; i < items; i++)
			pending_samples.push_back(rand_sample());
		while (pending_samples.size() > 0 || samples.valid || expected_bins.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int          total;
		logic [15:0] w, z;
		logic [16:0] n;
		errors = 0;
		cycles = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = fbad_pkg::REG_BIN_WIDTH;
		wr_data = '0;
		samples.valid = 1'b0;
		samples.sample = '0;
		samples.sample_ok = 1'b0;
		results.ready = 1'b0;
		cur_width = 16'd256;
		cur_zero = 16'd0;
		cur_count = 17'd1;
		run_pos = 0;
		edge_q8 = 0;
		acc_sum = '0;
		acc_cnt = 0;
		bins_done = 0;
		hist_ptr = 0;
		sample_taken = 1'b0;
		for (int i = 0; i < HIST_DEPTH; i++)
			history[i] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		pending_samples.push_back({32'h7FFFFFFF, 1'b1});
		pending_samples.push_back({32'h80000000, 1'b0});
		while (pending_samples.size() > 0 || samples.valid || expected_bins.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		run_phase(16'd384, 16'd3, 17'd10, 10);
		run_phase(16'd1, 16'd0, 17'd3, 3);
		run_phase(16'd65535, 16'd65535, 17'd2, 2);
		run_phase(16'd600, 16'd65535, 17'd65536, 3);
		run_phase(16'd512, 16'd1, 17'd3, 3);

		total = 0;
		while (total < 1500) begin
			quiet = (total > 600 && total < 900);
			case ($urandom_range(9))
				0: w = 16'd256;
				1: w = 16'($urandom_range(255, 1));
				2: w = 16'hFFFF;
				3: w = 16'($urandom_range(65535, 4096));
				default: w = 16'($urandom_range(4096, 257));
			endcase
			n = ($urandom_range(19) == 0) ? 17'($urandom_range(300, 100))
				: 17'($urandom_range(30, 1));
			case ($urandom_range(9))
				0: z = 16'($urandom_range(65535, n > 65535 ? 65535 : n));
				1: z = 16'hFFFF;
				default: z = 16'($urandom_range(n - 1));
			endcase
			run_phase(w, z, n, (n > 17'd300) ? 300 : int'(n));
			total += int'(n);
		end
		quiet = 1'b0;

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/fbad_pkg.sv
hw/rtl/fbad_if.sv
hw/rtl/fbad_ram.sv
hw/rtl/fbad_div.sv
hw/rtl/fractional_bin_average_decimator.sv
dv/tb_top.sv
